/* rtl/core/ccdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccdc_pkg
// Shared types and constants for the control command dedup cache.
// ----------------------------------------------------------------------------
package ccdc_pkg;

  localparam int KEY_W  = 8;
  localparam int TIME_W = 32;
  localparam int ENTRY_W = 3 * KEY_W + TIME_W;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

  typedef struct packed {
    logic load;      // capture input item, restart scan
    logic advance;   // step scan to next entry, read it
    logic wr_hit;    // refresh time of matched entry
    logic wr_new;    // record key at free entry (or entry 0)
    logic publish;   // move result into output register
  } ccdc_cmd_t;

  typedef struct packed {
    logic empty;     // no entry recorded
    logic hit;       // entry under test is a fresh match
    logic last;      // entry under test is the last recorded one
  } ccdc_status_t;

endpackage

/* rtl/core/ccdc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/ccdc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccdc_datapath
// Key/time capture, entry table, fill count, scan index and match logic.
// ----------------------------------------------------------------------------
module ccdc_datapath import ccdc_pkg::*; #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [TIME_W-1:0]   cfg_wr_data,
  input  logic [KEY_W-1:0]    source_id,
  input  logic [KEY_W-1:0]    seq_number,
  input  logic [KEY_W-1:0]    command_code,
  input  logic [TIME_W-1:0]   now_ms,
  input  ccdc_cmd_t           cmd,
  output ccdc_status_t        status,
  output logic                is_duplicate
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  logic [TIME_W-1:0]  timeout;
  logic [KEY_W-1:0]   src;
  logic [KEY_W-1:0]   seq;
  logic [KEY_W-1:0]   cmd_code;
  logic [TIME_W-1:0]  now;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   scan_idx_next;
  logic [CNT_W-1:0]   fill;
  logic               dup_pending;

  logic               full;
  logic [IDX_W-1:0]   new_idx;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  logic [KEY_W-1:0]   rd_src;
  logic [KEY_W-1:0]   rd_seq;
  logic [KEY_W-1:0]   rd_cmd;
  logic [TIME_W-1:0]  rd_time;
  logic [TIME_W-1:0]  age;

  assign full          = (fill == CNT_W'(CACHE_ENTRIES));
  assign new_idx       = full ? '0 : fill[IDX_W-1:0];
  assign scan_idx_next = IDX_W'(CNT_W'(scan_idx) + CNT_W'(1));

  assign ram_we      = cmd.wr_hit | cmd.wr_new;
  assign ram_wr_addr = cmd.wr_hit ? scan_idx : new_idx;
  assign ram_wr_data = {src, seq, cmd_code, now};
  assign ram_rd_addr = cmd.advance ? scan_idx_next : scan_idx;

  assign {rd_src, rd_seq, rd_cmd, rd_time} = ram_rd_data;
  assign age = now - rd_time;

  assign status.empty = (fill == '0);
  assign status.hit   = (rd_src == src) && (rd_seq == seq) && (rd_cmd == cmd_code) &&
                        (age < timeout);
  assign status.last  = ((CNT_W'(scan_idx) + CNT_W'(1)) >= fill);

  ccdc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
      fill    <= '0;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (cmd.wr_new && !full) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src      <= source_id;
      seq      <= seq_number;
      cmd_code <= command_code;
      now      <= now_ms;
      scan_idx <= '0;
    end else if (cmd.advance) begin
      scan_idx <= scan_idx_next;
    end
    if (ram_we) begin
      dup_pending <= cmd.wr_hit;
    end
    if (cmd.publish) begin
      is_duplicate <= dup_pending;
    end
  end

endmodule

/* rtl/core/ccdc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccdc_ctrl
// Sequencer: capture item, scan recorded entries, write back, hand off result.
// ----------------------------------------------------------------------------
module ccdc_ctrl import ccdc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  ccdc_status_t status,
  output ccdc_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (status.empty) begin
          cmd.wr_new = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.hit) begin
          cmd.wr_hit = 1'b1;
          state_next = S_DONE;
        end else if (!status.last) begin
          cmd.advance = 1'b1;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/control_command_dedup_cache_core.sv */
`timescale 1ns / 1ps
// Scan: one table entry is read and compared per cycle over the N recorded
//   entries (N = 0..CACHE_ENTRIES); a fresh match at entry k ends it early.
// Flow: the next item is taken while a result waits in the output register.
// Reset: synchronous; table empties at once (fill count), timeout = 5000 ms.
// ----------------------------------------------------------------------------
// control_command_dedup_cache_core
// Duplicate control message filter with a scanned key/time table.
// ----------------------------------------------------------------------------
module control_command_dedup_cache_core import ccdc_pkg::*; #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [TIME_W-1:0]  cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KEY_W-1:0]   source_id,
  input  logic [KEY_W-1:0]   seq_number,
  input  logic [KEY_W-1:0]   command_code,
  input  logic [TIME_W-1:0]  now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_duplicate
);

  ccdc_cmd_t    cmd;
  ccdc_status_t status;

  ccdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ccdc_datapath #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .source_id    (source_id),
    .seq_number   (seq_number),
    .command_code (command_code),
    .now_ms       (now_ms),
    .cmd          (cmd),
    .status       (status),
    .is_duplicate (is_duplicate)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for control_command_dedup_cache_core. Control message
// items go through a valid/ready driver with random idling. A cycle-free
// model of the key/time table predicts the duplicate flag of each accepted
// item, and a monitor compares every result in order. The timeout register
// is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import ccdc_pkg::*;

  localparam int TABLE_DEPTH    = 16;
  localparam int KEY_POOL       = 8;
  localparam int RAND_PER_PHASE = 325;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 300;
  localparam int DRAIN_CYCLES   = TABLE_DEPTH + 24;
  localparam int MAX_PRINTS     = 50;

  typedef struct packed {
    logic [KEY_W-1:0]  src;
    logic [KEY_W-1:0]  seq;
    logic [KEY_W-1:0]  cmd;
    logic [TIME_W-1:0] now;
  } ctrl_msg_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [TIME_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KEY_W-1:0]  source_id = '0;
  logic [KEY_W-1:0]  seq_number = '0;
  logic [KEY_W-1:0]  command_code = '0;
  logic [TIME_W-1:0] now_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              is_duplicate;

  control_command_dedup_cache_core #(
    .CACHE_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .source_id(source_id),
    .seq_number(seq_number),
    .command_code(command_code),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_duplicate(is_duplicate)
  );

  // Cache model state
  logic              slot_used [TABLE_DEPTH];
  ctrl_msg_t         slot_msg  [TABLE_DEPTH];
  logic [TIME_W-1:0] dup_window_ms;

  ctrl_msg_t         msg_queue [$];
  logic              expected_dup [$];
  ctrl_msg_t         key_pool [KEY_POOL];
  ctrl_msg_t         next_msg;
  ctrl_msg_t         taken_msg;
  logic              want_dup;
  logic [TIME_W-1:0] gen_clock = '0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                mismatches = 0;
  int                results_seen = 0;
  int                hold_left = 0;
  logic              long_hold_done = 1'b0;
  int                cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic predict_dup(input ctrl_msg_t m);
    logic [TIME_W-1:0] age;
    int                free_slot;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      age = m.now - slot_msg[k].now;
      if (slot_used[k] && slot_msg[k].src == m.src && slot_msg[k].seq == m.seq &&
          slot_msg[k].cmd == m.cmd && age < dup_window_ms) begin
        slot_msg[k].now = m.now;
        return 1'b1;
      end
    end
    // lowest free entry, entry 0 when full
    free_slot = 0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (!slot_used[k]) free_slot = k;
    end
    slot_used[free_slot] = 1'b1;
    slot_msg[free_slot]  = m;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken_msg = {source_id, seq_number, command_code, now_ms};
        expected_dup.push_back(predict_dup(taken_msg));
      end
      if (!in_valid || in_ready) begin
        if (msg_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_msg = msg_queue.pop_front();
          source_id    <= next_msg.src;
          seq_number   <= next_msg.seq;
          command_code <= next_msg.cmd;
          now_ms       <= next_msg.now;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_dup.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want_dup = expected_dup.pop_front();
          if (is_duplicate !== want_dup) begin
            report_mismatch($sformatf("result %0d is_duplicate got %b want %b",
                                      results_seen, is_duplicate, want_dup));
          end
        end
        results_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        // long back-pressure so the block fills and stalls its input
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_msg(input logic [KEY_W-1:0] src, input logic [KEY_W-1:0] seq,
                          input logic [KEY_W-1:0] cmd, input logic [TIME_W-1:0] now);
    ctrl_msg_t m;
    m = {src, seq, cmd, now};
    while (msg_queue.size() >= 4) @(negedge clk);
    msg_queue.push_back(m);
  endtask

  task automatic queue_random(input int count);
    int        pick;
    int        slot;
    ctrl_msg_t m;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95) gen_clock = $urandom;
      else if (pick >= 80) gen_clock += $urandom_range(3000, 12000);
      else if (pick >= 30) gen_clock += $urandom_range(1, 3000);
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, TABLE_DEPTH - 1);
      if (pick < 45 && slot_used[slot]) begin
        m = slot_msg[slot];
      end else if (pick < 85) begin
        m = key_pool[$urandom_range(0, KEY_POOL - 1)];
      end else begin
        m.src = $urandom;
        m.seq = $urandom;
        m.cmd = $urandom;
      end
      push_msg(m.src, m.seq, m.cmd, gen_clock);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (msg_queue.size() != 0 || in_valid || expected_dup.size() != 0) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [TIME_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    dup_window_ms = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      slot_used[k] = 1'b0;
      slot_msg[k]  = '0;
    end
    dup_window_ms = TIMEOUT_RESET;
    for (int k = 0; k < KEY_POOL; k++) begin
      key_pool[k] = {8'($urandom), 8'($urandom), 8'($urandom), 32'd0};
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender 31%, receiver 53% idle; reset timeout
    send_idle_pct = 31;
    recv_idle_pct = 53;
    push_msg(8'h00, 8'h00, 8'h00, 32'd0);          // empty table never matches
    push_msg(8'h00, 8'h00, 8'h00, 32'd4999);       // age just below timeout
    push_msg(8'h00, 8'h00, 8'h00, 32'd9999);       // age equals timeout: stale
    push_msg(8'h00, 8'h00, 8'h00, 32'd10000);      // second copy matches
    push_msg(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    push_msg(8'hFF, 8'hFF, 8'hFF, 32'h0000_0010);  // tick wrapped
    push_msg(8'h12, 8'h34, 8'h56, 32'd1000);
    push_msg(8'h12, 8'h34, 8'h56, 32'd999);        // stored time in the future
    push_msg(8'h00, 8'h00, 8'h01, 32'd10000);
    push_msg(8'h00, 8'h01, 8'h00, 32'd10000);
    push_msg(8'h01, 8'h00, 8'h00, 32'd10000);
    for (int k = 0; k < 8; k++) begin
      push_msg(8'h80 + 8'(k), 8'(k), 8'hA5, 32'd10000 + 32'(k));
    end
    push_msg(8'h5A, 8'h5A, 8'h5A, 32'd10010);      // table full: entry 0 reused
    push_msg(8'h5A, 8'h5A, 8'h5A, 32'd10011);
    push_msg(8'h00, 8'h00, 8'h00, 32'd10012);
    gen_clock = 32'd10012;
    queue_random(RAND_PER_PHASE / 2);
    drain();
    queue_random(RAND_PER_PHASE - RAND_PER_PHASE / 2);
    drain();

    write_timeout('0);
    queue_random(RAND_PER_PHASE);
    drain();

    // sender 53%, receiver 31% idle
    send_idle_pct = 53;
    recv_idle_pct = 31;
    write_timeout('1);
    push_msg(8'hC3, 8'h3C, 8'h99, 32'h8000_0000);
    push_msg(8'hC3, 8'h3C, 8'h99, 32'h7FFF_FFFF);  // largest age is never fresh
    queue_random(RAND_PER_PHASE);
    drain();

    write_timeout(32'd1);
    queue_random(RAND_PER_PHASE);
    drain();

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_timeout(32'($urandom_range(200, 20000)));
    queue_random(RAND_PER_PHASE);
    drain();

    write_timeout(TIMEOUT_RESET);
    queue_random(RAND_PER_PHASE);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_dup.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
